@@ src/stu_pkg.sv @@
// types, character codes and helpers shared by the script tokenizer
`timescale 1ns / 1ps
`default_nettype none

package stu_pkg;

  // scan mode, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_SLASH   = 6'b000010,
    MODE_COMMENT = 6'b000100,
    MODE_QSTART  = 6'b001000,
    MODE_QBODY   = 6'b010000,
    MODE_WORD    = 6'b100000
  } scan_mode_e;

  // token kinds
  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_QUOTE = 2'd1;
  localparam logic [1:0] KIND_PUNCT = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // one result item
  typedef struct packed {
    logic       has_char;
    logic [7:0] token_char;
    logic       token_first;
    logic       token_last;
    logic [1:0] token_kind;
    logic       end_of_text;
    logic       last_result;
  } tok_result_t;

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_APOS) || (c == CH_COLON);
  endfunction

  // space, control codes and the upper half count as whitespace
  function automatic logic is_space(input logic [7:0] c);
    return (c <= CH_SPACE) || c[7];
  endfunction

  function automatic tok_result_t make_result(
    input logic       has,
    input logic [7:0] ch,
    input logic       first,
    input logic       last,
    input logic [1:0] kind,
    input logic       eot
  );
    tok_result_t r;
    r.has_char    = has;
    r.token_char  = ch;
    r.token_first = first;
    r.token_last  = last;
    r.token_kind  = kind;
    r.end_of_text = eot;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/script_tokenizer_unit.sv @@
// streaming tokenizer: one text byte in, up to two token results out
`timescale 1ns / 1ps
`default_nettype none

// Takes one text byte per transaction and returns token characters with first/last
// marks, kind, end-of-text and a last-result flag. The byte is decoded against a
// small one-hot scan mode register in the same cycle it is accepted, and its zero,
// one or two results go into a four-entry result queue. A byte is accepted in any
// cycle in which the queue has room for two results, so bytes stream at one per
// cycle; the output side delivers one result per cycle while out_stall_i is low,
// so a run of bytes that each make two results (a word closed by punctuation, a
// held slash followed by a word or punctuation character) is paced by the queue.
// Results reach the output no earlier than the cycle after their byte is accepted.
module script_tokenizer_unit
  import stu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_char_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            has_char_o,
  output logic [7:0]      token_char_o,
  output logic            token_first_o,
  output logic            token_last_o,
  output logic [1:0]      token_kind_o,
  output logic            end_of_text_o,
  output logic            last_result_o
);

  scan_mode_e  mode_q, mode_d;
  tok_result_t res0, res1;
  logic [1:0]  res_cnt;

  tok_result_t fifo_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q, count_d;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // byte decode against the scan mode
  always_comb begin
    logic [7:0] c;
    tok_result_t w_close;
    c       = in_char_i;
    res0    = make_result(1'b0, CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b0);
    res1    = res0;
    res_cnt = 2'd0;
    mode_d  = mode_q;
    w_close = make_result(1'b0, CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
    unique case (mode_q)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else if (c == CH_NUL) begin
          res0    = make_result(1'b1, CH_SLASH, 1'b1, 1'b1, KIND_WORD, 1'b1);
          res_cnt = 2'd1;
          mode_d  = MODE_IDLE;
        end else if (is_punct(c)) begin
          res0    = make_result(1'b1, CH_SLASH, 1'b1, 1'b1, KIND_WORD, 1'b0);
          res1    = make_result(1'b1, c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
          res_cnt = 2'd2;
          mode_d  = MODE_IDLE;
        end else if (is_space(c)) begin
          res0    = make_result(1'b1, CH_SLASH, 1'b1, 1'b1, KIND_WORD, 1'b0);
          res_cnt = 2'd1;
          mode_d  = MODE_IDLE;
        end else begin
          res0    = make_result(1'b1, CH_SLASH, 1'b1, 1'b0, KIND_WORD, 1'b0);
          res1    = make_result(1'b1, c, 1'b0, 1'b0, KIND_WORD, 1'b0);
          res_cnt = 2'd2;
          mode_d  = MODE_WORD;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NUL) begin
          res0    = make_result(1'b0, CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
          res_cnt = 2'd1;
          mode_d  = MODE_IDLE;
        end else if (c == CH_NL) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_QSTART, MODE_QBODY: begin
        if ((c == CH_DQUOTE) || (c == CH_NUL)) begin
          res0    = make_result(1'b0, CH_NUL, mode_q == MODE_QSTART, 1'b1, KIND_QUOTE,
                                c == CH_NUL);
          res_cnt = 2'd1;
          mode_d  = MODE_IDLE;
        end else begin
          res0    = make_result(1'b1, c, mode_q == MODE_QSTART, 1'b0, KIND_QUOTE, 1'b0);
          res_cnt = 2'd1;
          mode_d  = MODE_QBODY;
        end
      end
      MODE_WORD: begin
        res_cnt = 2'd1;
        if (c == CH_NUL) begin
          res0             = w_close;
          res0.end_of_text = 1'b1;
          mode_d           = MODE_IDLE;
        end else if (is_punct(c)) begin
          res0    = w_close;
          res1    = make_result(1'b1, c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
          res_cnt = 2'd2;
          mode_d  = MODE_IDLE;
        end else if (is_space(c)) begin
          res0   = w_close;
          mode_d = MODE_IDLE;
        end else begin
          res0 = make_result(1'b1, c, 1'b0, 1'b0, KIND_WORD, 1'b0);
        end
      end
      default: begin
        // idle between tokens; unused codes behave the same
        mode_d = MODE_IDLE;
        if (c == CH_NUL) begin
          res0    = make_result(1'b0, CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
          res_cnt = 2'd1;
        end else if (is_space(c)) begin
          mode_d = MODE_IDLE;
        end else if (c == CH_SLASH) begin
          mode_d = MODE_SLASH;
        end else if (c == CH_DQUOTE) begin
          mode_d = MODE_QSTART;
        end else if (is_punct(c)) begin
          res0    = make_result(1'b1, c, 1'b1, 1'b1, KIND_PUNCT, 1'b0);
          res_cnt = 2'd1;
        end else begin
          res0    = make_result(1'b1, c, 1'b1, 1'b0, KIND_WORD, 1'b0);
          res_cnt = 2'd1;
          mode_d  = MODE_WORD;
        end
      end
    endcase
    // mark the last result of this byte
    if (res_cnt == 2'd2) begin
      res1.last_result = 1'b1;
    end else begin
      res0.last_result = 1'b1;
    end
  end

  // scan mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (in_acc) begin
      mode_q <= mode_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc && (res_cnt != 2'd0)) begin
      fifo_q[wr_ptr_q] <= res0;
      if (res_cnt == 2'd2) begin
        fifo_q[wr_ptr_q + 2'd1] <= res1;
      end
    end
  end

  // result queue pointers and fill
  always_comb begin
    count_d = count_q - {2'b00, out_acc};
    if (in_acc) begin
      count_d = count_d + {1'b0, res_cnt};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + res_cnt;
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_d;
    end
  end

  // take a byte only when two queue slots are free
  assign in_stall_o  = (count_q >= 3'd3);
  assign out_valid_o = (count_q != 3'd0);

  // output transaction fields
  always_comb begin
    tok_result_t head;
    head          = fifo_q[rd_ptr_q];
    has_char_o    = head.has_char;
    token_char_o  = head.token_char;
    token_first_o = head.token_first;
    token_last_o  = head.token_last;
    token_kind_o  = head.token_kind;
    end_of_text_o = head.end_of_text;
    last_result_o = head.last_result;
  end

endmodule

`default_nettype wire

@@ src/stu_checker.sv @@
// port-level checks for the script tokenizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module stu_checker
  import stu_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       has_char_o,
  input wire logic [7:0] token_char_o,
  input wire logic       token_first_o,
  input wire logic       token_last_o,
  input wire logic [1:0] token_kind_o,
  input wire logic       end_of_text_o,
  input wire logic       last_result_o
);

  // end of text always closes the results of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_text_o) |-> last_result_o)
  else $error("end of text not on last result");

  // a result without a character carries a zero character code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_char_o) |-> (token_char_o == CH_NUL))
  else $error("empty result with nonzero character");

  // punctuation is always a complete one-character token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == KIND_PUNCT)) |->
      (has_char_o && token_first_o && token_last_o))
  else $error("malformed punctuation token");

  // with nothing queued the input is never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
  else $error("input stalled with empty output");

  // a stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(token_char_o) && $stable(last_result_o)))
  else $error("stalled output changed");

endmodule

bind script_tokenizer_unit stu_checker u_stu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .has_char_o    (has_char_o),
  .token_char_o  (token_char_o),
  .token_first_o (token_first_o),
  .token_last_o  (token_last_o),
  .token_kind_o  (token_kind_o),
  .end_of_text_o (end_of_text_o),
  .last_result_o (last_result_o)
);

`default_nettype wire
